// ===== rtl/text_frame_buffer_cursor_engine_assert.svh =====
// assertion macros used by the checker file of the text frame buffer
// no dependencies
`ifndef TEXT_FRAME_BUFFER_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_FRAME_BUFFER_CURSOR_ENGINE_ASSERT_SVH

// consequence in the cycle after the antecedent
`define TFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfb check failed");

// consequence in the same cycle as the antecedent
`define TFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfb check failed");

`endif

// ===== rtl/tfb_pkg.sv =====
// types and constants of the text frame buffer
// no dependencies
package tfb_pkg;

	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [2:0] FN_PUT    = 3'd0;
	localparam logic [2:0] FN_SET    = 3'd1;
	localparam logic [2:0] FN_MOVE   = 3'd2;
	localparam logic [2:0] FN_SHIFT  = 3'd3;
	localparam logic [2:0] FN_ROTATE = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;
	localparam logic [2:0] FN_READ   = 3'd6;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SPACE,
		CELL_FROM_RIGHT,
		CELL_FROM_LEFT,
		CELL_FROM_BELOW,
		CELL_FROM_ABOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  char_in;
	} cell_ctl_t;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] up;
		logic [7:0] down;
	} cell_nbr_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] char_in;
		logic [2:0] row;
		logic [5:0] col;
		logic [1:0] direction;
		logic [5:0] band_offset;
		logic [5:0] band_width;
	} cmd_t;

endpackage

// ===== rtl/tfb_cell.sv =====
// one character cell of the grid, loads from itself, the command, a space or a neighbor
// depends on tfb_pkg
module tfb_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tfb_pkg::cell_ctl_t ctl,
	input  tfb_pkg::cell_nbr_t nbr,
	output logic [7:0]        value
);

	logic [7:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= tfb_pkg::SPACE_CHAR;
		end else begin
			unique case (ctl.op)
				tfb_pkg::CELL_LOAD:       value_q <= ctl.char_in;
				tfb_pkg::CELL_SPACE:      value_q <= tfb_pkg::SPACE_CHAR;
				tfb_pkg::CELL_FROM_RIGHT: value_q <= nbr.right;
				tfb_pkg::CELL_FROM_LEFT:  value_q <= nbr.left;
				tfb_pkg::CELL_FROM_BELOW: value_q <= nbr.down;
				tfb_pkg::CELL_FROM_ABOVE: value_q <= nbr.up;
				default:                  value_q <= value_q;
			endcase
		end
	end

	assign value = value_q;

endmodule

// ===== rtl/tfb_cursor.sv =====
// cursor register with step, wrap, set and band follow logic
// depends on tfb_pkg
module tfb_cursor #(
	parameter int NUM_ROWS = 4,
	parameter int NUM_COLS = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  tfb_pkg::cmd_t cmd,
	output logic [1:0]    cur_row,
	output logic [5:0]    cur_col
);

	localparam logic [1:0] ROW_LAST = 2'(NUM_ROWS - 1);
	localparam logic [5:0] COL_LAST = 6'(NUM_COLS - 1);

	logic [1:0] row_q, row_d, set_row, up_row, down_row, right_row, left_row;
	logic [5:0] col_q, col_d, set_col, right_col, left_col;
	logic [6:0] band_end;
	logic       row_band, col_band, off_ok;

	always_comb begin
		set_row   = (cmd.row < 3'(NUM_ROWS)) ? cmd.row[1:0] : 2'd0;
		set_col   = (cmd.col < 6'(NUM_COLS)) ? cmd.col : 6'd0;
		up_row    = (row_q == 2'd0) ? ROW_LAST : row_q - 2'd1;
		down_row  = (row_q >= ROW_LAST) ? 2'd0 : row_q + 2'd1;
		right_col = (col_q >= COL_LAST) ? 6'd0 : col_q + 6'd1;
		right_row = (col_q >= COL_LAST) ? down_row : row_q;
		left_col  = (col_q == 6'd0) ? COL_LAST : col_q - 6'd1;
		left_row  = (col_q == 6'd0) ? up_row : row_q;
		band_end  = {1'b0, cmd.band_offset} + {1'b0, cmd.band_width};
		row_band  = (7'(row_q) >= {1'b0, cmd.band_offset}) && (7'(row_q) < band_end);
		col_band  = ({1'b0, col_q} >= {1'b0, cmd.band_offset}) && ({1'b0, col_q} < band_end);
		off_ok    = (cmd.direction == tfb_pkg::DIR_LEFT || cmd.direction == tfb_pkg::DIR_RIGHT)
			? (cmd.band_offset < 6'(NUM_ROWS)) : (cmd.band_offset < 6'(NUM_COLS));

		row_d = row_q;
		col_d = col_q;
		unique case (cmd.func)
			tfb_pkg::FN_PUT: begin
				row_d = right_row;
				col_d = right_col;
			end
			tfb_pkg::FN_SET: begin
				row_d = set_row;
				col_d = set_col;
			end
			tfb_pkg::FN_MOVE: begin
				unique case (cmd.direction)
					tfb_pkg::DIR_LEFT: begin
						row_d = left_row;
						col_d = left_col;
					end
					tfb_pkg::DIR_RIGHT: begin
						row_d = right_row;
						col_d = right_col;
					end
					tfb_pkg::DIR_UP:   row_d = up_row;
					default:           row_d = down_row;
				endcase
			end
			tfb_pkg::FN_SHIFT: begin
				if (off_ok) begin
					unique case (cmd.direction)
						tfb_pkg::DIR_LEFT: begin
							row_d = cmd.band_offset[1:0];
							col_d = COL_LAST;
						end
						tfb_pkg::DIR_RIGHT: begin
							row_d = cmd.band_offset[1:0];
							col_d = 6'd0;
						end
						tfb_pkg::DIR_UP: begin
							row_d = ROW_LAST;
							col_d = cmd.band_offset;
						end
						default: begin
							row_d = 2'd0;
							col_d = cmd.band_offset;
						end
					endcase
				end
			end
			tfb_pkg::FN_ROTATE: begin
				if (off_ok) begin
					unique case (cmd.direction)
						tfb_pkg::DIR_LEFT:  if (row_band) col_d = left_col;
						tfb_pkg::DIR_RIGHT: if (row_band) col_d = right_col;
						tfb_pkg::DIR_UP:    if (col_band) row_d = up_row;
						default:            if (col_band) row_d = down_row;
					endcase
				end
			end
			tfb_pkg::FN_CLEAR: begin
				row_d = 2'd0;
				col_d = 6'd0;
			end
			default: begin
				row_d = row_q;
				col_d = col_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
			col_q <= 6'd0;
		end else if (accept) begin
			row_q <= row_d;
			col_q <= col_d;
		end
	end

	assign cur_row = row_q;
	assign cur_col = col_q;

endmodule

// ===== rtl/text_frame_buffer_cursor_engine.sv =====
// top level of the text frame buffer: grid of linked cells, cursor, result register
// depends on tfb_pkg, tfb_cell, tfb_cursor
//
// Usage:
// Commands enter on cmd_valid/cmd_stall with func, char_in, row, col, direction,
// band_offset and band_width. Each command gives one result on rsp_valid/rsp_stall:
// char_out (cell read, else 0) and the cursor position after the command.
// The grid is a NUM_ROWS x NUM_COLS array of character cells, each wired to its four
// neighbors with wraparound, so a band shift or rotate moves every cell of the band at once.
// The result is registered and shows in the cycle after a command is accepted.
// Throughput is one command per cycle while the result side does not stall;
// the single result register is the limit.
// While a result waits under rsp_stall, cmd_stall is high and no command is taken;
// the result fields hold.
// Reset fills every cell with a space, homes the cursor and empties the result
// register; the block takes commands in the first cycle after reset.
module text_frame_buffer_cursor_engine #(
	parameter int NUM_ROWS = 4,
	parameter int NUM_COLS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] func,
	input  logic [7:0] char_in,
	input  logic [2:0] row,
	input  logic [5:0] col,
	input  logic [1:0] direction,
	input  logic [5:0] band_offset,
	input  logic [5:0] band_width,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] char_out,
	output logic [1:0] cursor_row,
	output logic [5:0] cursor_col
);

	tfb_pkg::cmd_t cmd;
	logic          accept;
	logic          rsp_valid_q;
	logic [7:0]    char_out_q;
	logic [1:0]    cur_row;
	logic [5:0]    cur_col;
	logic [1:0]    rd_row;
	logic [5:0]    rd_col;
	logic [6:0]    band_end;
	logic [7:0]    rd_data;
	logic          is_shift;

	logic [7:0] cell_val [NUM_ROWS][NUM_COLS];
	logic [7:0] rd_part  [NUM_ROWS][NUM_COLS];

	assign cmd = '{func: func, char_in: char_in, row: row, col: col, direction: direction,
		band_offset: band_offset, band_width: band_width};

	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign rd_row    = (row < 3'(NUM_ROWS)) ? row[1:0] : 2'd0;
	assign rd_col    = (col < 6'(NUM_COLS)) ? col : 6'd0;
	assign band_end  = {1'b0, band_offset} + {1'b0, band_width};
	assign is_shift  = (func == tfb_pkg::FN_SHIFT);

	tfb_cursor #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.cur_row(cur_row),
		.cur_col(cur_col)
	);

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
			localparam int CR = (c + 1) % NUM_COLS;
			localparam int CL = (c + NUM_COLS - 1) % NUM_COLS;
			localparam int RD = (r + 1) % NUM_ROWS;
			localparam int RU = (r + NUM_ROWS - 1) % NUM_ROWS;

			tfb_pkg::cell_ctl_t ctl;
			tfb_pkg::cell_nbr_t nbr;
			logic               in_rows, in_cols;

			assign nbr = '{left: cell_val[r][CL], right: cell_val[r][CR],
				up: cell_val[RU][c], down: cell_val[RD][c]};
			assign in_rows = (7'(r) >= {1'b0, band_offset}) && (7'(r) < band_end);
			assign in_cols = (7'(c) >= {1'b0, band_offset}) && (7'(c) < band_end);
			assign rd_part[r][c] = (2'(r) == rd_row && 6'(c) == rd_col) ? cell_val[r][c] : 8'd0;

			always_comb begin
				ctl.char_in = char_in;
				ctl.op      = tfb_pkg::CELL_HOLD;
				if (accept) begin
					unique case (func)
						tfb_pkg::FN_PUT: begin
							if (2'(r) == cur_row && 6'(c) == cur_col) ctl.op = tfb_pkg::CELL_LOAD;
						end
						tfb_pkg::FN_CLEAR: ctl.op = tfb_pkg::CELL_SPACE;
						tfb_pkg::FN_SHIFT, tfb_pkg::FN_ROTATE: begin
							unique case (direction)
								tfb_pkg::DIR_LEFT: begin
									if (in_rows) ctl.op = (is_shift && c == NUM_COLS - 1)
										? tfb_pkg::CELL_SPACE : tfb_pkg::CELL_FROM_RIGHT;
								end
								tfb_pkg::DIR_RIGHT: begin
									if (in_rows) ctl.op = (is_shift && c == 0)
										? tfb_pkg::CELL_SPACE : tfb_pkg::CELL_FROM_LEFT;
								end
								tfb_pkg::DIR_UP: begin
									if (in_cols) ctl.op = (is_shift && r == NUM_ROWS - 1)
										? tfb_pkg::CELL_SPACE : tfb_pkg::CELL_FROM_BELOW;
								end
								default: begin
									if (in_cols) ctl.op = (is_shift && r == 0)
										? tfb_pkg::CELL_SPACE : tfb_pkg::CELL_FROM_ABOVE;
								end
							endcase
						end
						default: ctl.op = tfb_pkg::CELL_HOLD;
					endcase
				end
			end

			tfb_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (ctl),
				.nbr   (nbr),
				.value (cell_val[r][c])
			);
		end
	end

	always_comb begin
		rd_data = 8'd0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				rd_data = rd_data | rd_part[r][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_out_q <= (func == tfb_pkg::FN_READ) ? rd_data : 8'd0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign char_out   = char_out_q;
	assign cursor_row = cur_row;
	assign cursor_col = cur_col;

endmodule

// ===== rtl/tfb_checker.sv =====
// port-level checks of the text frame buffer, bound to the top level
// depends on tfb_pkg and text_frame_buffer_cursor_engine_assert.svh
`include "text_frame_buffer_cursor_engine_assert.svh"

module tfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic [2:0] func,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] char_out,
	input logic [1:0] cursor_row,
	input logic [5:0] cursor_col
);

	logic cmd_take;
	logic rsp_take;

	assign cmd_take = cmd_valid && !cmd_stall;
	assign rsp_take = rsp_valid && !rsp_stall;

	// every item gives a result in the next cycle
	`TFB_ASSERT_NEXT(a_rsp_after_cmd, clk, arst_n, cmd_take, rsp_valid)
	// a taken result without a new item leaves the output empty
	`TFB_ASSERT_NEXT(a_rsp_drains, clk, arst_n, rsp_take && !cmd_take, !rsp_valid)
	// only a cell read returns a character
	`TFB_ASSERT_NEXT(a_char_zero, clk, arst_n, cmd_take && func != tfb_pkg::FN_READ,
		char_out == 8'd0)
	// clear homes the cursor
	`TFB_ASSERT_NEXT(a_clear_home, clk, arst_n, cmd_take && func == tfb_pkg::FN_CLEAR,
		cursor_row == 2'd0 && cursor_col == 6'd0)
	// a stalled result keeps its cursor
	`TFB_ASSERT_NEXT(a_stall_hold, clk, arst_n, rsp_valid && rsp_stall,
		$stable(cursor_row) && $stable(cursor_col))

endmodule

bind text_frame_buffer_cursor_engine tfb_checker u_tfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.func      (func),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.char_out  (char_out),
	.cursor_row(cursor_row),
	.cursor_col(cursor_col)
);
